[hdl/coo_to_csc_converter_defines.svh]
// Assertion macros used by the converter's top-level RTL file.
`ifndef COO_TO_CSC_CONVERTER_DEFINES_SVH
`define COO_TO_CSC_CONVERTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CCSC_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define CCSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ccsc_pkg.sv]
// Shared constants and types of the sparse tuple to column format converter.
package ccsc_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int VAL_W  = 64;
    localparam int IDX_W  = 13;
    localparam int CNT_W  = 13;
    localparam int NCOL_W = 11;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int CTAB_DEPTH = MAX_COLUMNS + 1;
    localparam int CADDR_W    = $clog2(CTAB_DEPTH);
    localparam int EADDR_W    = $clog2(MAX_ENTRIES);
    localparam int TUPLE_W    = ROW_W + COL_W + VAL_W;
    localparam int SORT_W     = ROW_W + VAL_W;

    localparam int S_TDATA_W = ((ROW_W + COL_W + VAL_W + IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CNT_W + ROW_W + VAL_W + 7) / 8) * 8;

    localparam logic [NCOL_W-1:0]  NCOL_MAX   = NCOL_W'(MAX_COLUMNS);
    localparam logic [NCOL_W-1:0]  ROW_LIMIT  = NCOL_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0]   ENTRY_MAX  = CNT_W'(MAX_ENTRIES);
    localparam logic [CADDR_W-1:0] CADDR_LAST = CADDR_W'(MAX_COLUMNS);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD       = 2'd0,
        OP_CONVERT    = 2'd1,
        OP_READ_START = 2'd2,
        OP_READ_ENTRY = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK            = 2'd0,
        ST_BAD_LOAD      = 2'd1,
        ST_NOT_CONVERTED = 2'd2,
        ST_BAD_INDEX     = 2'd3
    } status_t;

endpackage

[hdl/ccsc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ccsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

[hdl/coo_to_csc_converter.sv]
// Top level of the converter from sparse tuples to compressed sparse column form.
//
//   Port group   Direction  Moves
//   cfg_write_*  in         num_columns register write
//   s_*          in         one operation per transfer
//   m_*          out        one result per accepted operation
//
// A load or a read reaches m_* through the pending and output registers; two loads to the
// same column follow each other through a forwarded count read-modify-write.
// A convert walks the 1025-entry count memory, then, if tuples are stored, scatters
// each one through states S_SC_A, S_SC_B and S_SC_C via the slot pointer memory.
// After reset a clearing pass zeroes the count memory entry by entry; no operation is
// taken meanwhile. A stalled result holds back any operation after the pending one.
`include "coo_to_csc_converter_defines.svh"

module coo_to_csc_converter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [ccsc_pkg::NCOL_W-1:0]    cfg_write_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row, column, value, index
    input  logic [ccsc_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [ccsc_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // col_start, out_row, out_value
    output logic [ccsc_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [ccsc_pkg::ST_W-1:0]      m_tuser
);

    import ccsc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PREFIX = 6'b000100,
        S_SC_A   = 6'b001000,
        S_SC_B   = 6'b010000,
        S_SC_C   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [NCOL_W-1:0]    num_columns_reg;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic                 converted_reg, converted_next;
    logic [CNT_W-1:0]     walk_reg, walk_next;
    logic [CNT_W-1:0]     sum_reg, sum_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [CADDR_W-1:0]   wb_idx_reg, wb_idx_next;

    logic                 ld2_valid_reg;
    logic [CADDR_W-1:0]   ld2_addr_reg;
    logic                 fwd_valid_reg;
    logic [CADDR_W-1:0]   fwd_addr_reg;
    logic [CNT_W-1:0]     fwd_data_reg;

    logic                 p_valid_reg;
    opcode_t              p_op_reg;
    status_t              p_status_reg;
    logic                 m_tvalid_reg;
    logic [CNT_W-1:0]     col_start_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [VAL_W-1:0]     out_value_reg;
    status_t              status_reg;

    opcode_t              in_op;
    logic [ROW_W-1:0]     in_row;
    logic [COL_W-1:0]     in_col;
    logic [VAL_W-1:0]     in_value;
    logic [IDX_W-1:0]     in_index;
    logic [NCOL_W-1:0]    ncol;
    logic [CNT_W-1:0]     cnt_eff;
    logic                 load_bad;
    status_t              in_status;
    logic                 accept;
    logic                 p_adv;
    logic                 load_ok;
    logic                 prefix_issue;
    logic                 scat_last;
    logic [CNT_W-1:0]     sum_cur;
    logic [CNT_W-1:0]     inc_count;

    logic                 cnt_we, cnt_re;
    logic [CADDR_W-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]     cnt_wdata, cnt_rdata;
    logic                 start_re;
    logic [CNT_W-1:0]     start_rdata;
    logic                 ns_we;
    logic [CADDR_W-1:0]   ns_waddr;
    logic [CNT_W-1:0]     ns_wdata, ns_rdata;
    logic                 tup_we;
    logic [TUPLE_W-1:0]   tup_wdata, tup_rdata;
    logic [ROW_W-1:0]     tup_row;
    logic [COL_W-1:0]     tup_col;
    logic [VAL_W-1:0]     tup_value;
    logic                 sort_re;
    logic [SORT_W-1:0]    sort_rdata;

    assign in_op    = opcode_t'(s_tuser);
    assign in_row   = s_tdata[ROW_W-1:0];
    assign in_col   = s_tdata[ROW_W +: COL_W];
    assign in_value = s_tdata[ROW_W + COL_W +: VAL_W];
    assign in_index = s_tdata[ROW_W + COL_W + VAL_W +: IDX_W];

    assign ncol    = (num_columns_reg > NCOL_MAX) ? NCOL_MAX : num_columns_reg;
    assign cnt_eff = converted_reg ? '0 : entry_count_reg;

    assign p_adv    = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && (!p_valid_reg || p_adv);
    assign accept   = s_tvalid && s_tready;

    assign load_bad = (NCOL_W'(in_col) >= ncol) || (NCOL_W'(in_row) >= ROW_LIMIT)
                      || (cnt_eff >= ENTRY_MAX);

    always_comb
    begin
        unique case (in_op)
            OP_LOAD:
            begin
                in_status = load_bad ? ST_BAD_LOAD : ST_OK;
            end
            OP_CONVERT:
            begin
                in_status = ST_OK;
            end
            OP_READ_START:
            begin
                priority if (!converted_reg)
                    in_status = ST_NOT_CONVERTED;
                else if (in_index > IDX_W'(ncol))
                    in_status = ST_BAD_INDEX;
                else
                    in_status = ST_OK;
            end
            OP_READ_ENTRY:
            begin
                priority if (!converted_reg)
                    in_status = ST_NOT_CONVERTED;
                else if ((in_index >= entry_count_reg) || (in_index >= ENTRY_MAX))
                    in_status = ST_BAD_INDEX;
                else
                    in_status = ST_OK;
            end
        endcase
    end

    assign load_ok      = accept && (in_op == OP_LOAD) && !load_bad;
    assign prefix_issue = (state_reg == S_PREFIX) && (walk_reg <= CNT_W'(MAX_COLUMNS));
    assign scat_last    = (walk_reg + CNT_W'(1)) == entry_count_reg;
    assign sum_cur      = sum_reg + cnt_rdata;

    assign inc_count = ((fwd_valid_reg && (fwd_addr_reg == ld2_addr_reg)) ? fwd_data_reg
                                                                           : cnt_rdata)
                       + CNT_W'(1);

    assign {tup_value, tup_col, tup_row} = tup_rdata;

    // Column count memory: load increments, the prefix walk and the reset pass clear it.
    assign cnt_re    = load_ok || prefix_issue;
    assign cnt_raddr = (state_reg == S_PREFIX) ? walk_reg[CADDR_W-1:0]
                                               : CADDR_W'(in_col) + CADDR_W'(1);
    assign cnt_we    = ld2_valid_reg || (state_reg == S_CLEAR)
                       || ((state_reg == S_PREFIX) && wb_valid_reg);
    always_comb
    begin
        priority if (ld2_valid_reg)
        begin
            cnt_waddr = ld2_addr_reg;
            cnt_wdata = inc_count;
        end
        else if (state_reg == S_CLEAR)
        begin
            cnt_waddr = walk_reg[CADDR_W-1:0];
            cnt_wdata = '0;
        end
        else
        begin
            cnt_waddr = wb_idx_reg;
            cnt_wdata = '0;
        end
    end

    ccsc_ram #(.WIDTH(CNT_W), .DEPTH(CTAB_DEPTH)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign start_re = accept && (in_op == OP_READ_START) && (in_status == ST_OK);

    ccsc_ram #(.WIDTH(CNT_W), .DEPTH(CTAB_DEPTH)) u_start_ram (
        .clk   (clk),
        .we    ((state_reg == S_PREFIX) && wb_valid_reg),
        .waddr (wb_idx_reg),
        .wdata (sum_cur),
        .re    (start_re),
        .raddr (in_index[CADDR_W-1:0]),
        .rdata (start_rdata)
    );

    assign ns_we    = ((state_reg == S_PREFIX) && wb_valid_reg) || (state_reg == S_SC_C);
    assign ns_waddr = (state_reg == S_SC_C) ? CADDR_W'(tup_col) : wb_idx_reg;
    assign ns_wdata = (state_reg == S_SC_C) ? ns_rdata + CNT_W'(1) : sum_cur;

    ccsc_ram #(.WIDTH(CNT_W), .DEPTH(CTAB_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (ns_we),
        .waddr (ns_waddr),
        .wdata (ns_wdata),
        .re    (state_reg == S_SC_B),
        .raddr (CADDR_W'(tup_col)),
        .rdata (ns_rdata)
    );

    assign tup_we    = load_ok;
    assign tup_wdata = {in_value, in_col, in_row};

    ccsc_ram #(.WIDTH(TUPLE_W), .DEPTH(MAX_ENTRIES)) u_tuple_ram (
        .clk   (clk),
        .we    (tup_we),
        .waddr (cnt_eff[EADDR_W-1:0]),
        .wdata (tup_wdata),
        .re    (state_reg == S_SC_A),
        .raddr (walk_reg[EADDR_W-1:0]),
        .rdata (tup_rdata)
    );

    assign sort_re = accept && (in_op == OP_READ_ENTRY) && (in_status == ST_OK);

    ccsc_ram #(.WIDTH(SORT_W), .DEPTH(MAX_ENTRIES)) u_sorted_ram (
        .clk   (clk),
        .we    (state_reg == S_SC_C),
        .waddr (ns_rdata[EADDR_W-1:0]),
        .wdata ({tup_value, tup_row}),
        .re    (sort_re),
        .raddr (in_index[EADDR_W-1:0]),
        .rdata (sort_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        converted_next   = converted_reg;
        walk_next        = walk_reg;
        sum_next         = sum_reg;
        wb_valid_next    = 1'b0;
        wb_idx_next      = wb_idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                walk_next = walk_reg + CNT_W'(1);
                if (walk_reg[CADDR_W-1:0] == CADDR_LAST)
                begin
                    walk_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && (in_op == OP_LOAD))
                begin
                    converted_next   = 1'b0;
                    entry_count_next = load_bad ? cnt_eff : cnt_eff + CNT_W'(1);
                end
                if (accept && (in_op == OP_CONVERT) && !converted_reg)
                begin
                    walk_next  = '0;
                    sum_next   = '0;
                    state_next = S_PREFIX;
                end
            end
            S_PREFIX:
            begin
                if (prefix_issue)
                begin
                    walk_next = walk_reg + CNT_W'(1);
                end
                wb_valid_next = prefix_issue;
                wb_idx_next   = walk_reg[CADDR_W-1:0];
                if (wb_valid_reg)
                begin
                    sum_next = sum_cur;
                    if (wb_idx_reg == CADDR_LAST)
                    begin
                        walk_next = '0;
                        if (entry_count_reg == '0)
                        begin
                            converted_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SC_A;
                        end
                    end
                end
            end
            S_SC_A:
            begin
                state_next = S_SC_B;
            end
            S_SC_B:
            begin
                state_next = S_SC_C;
            end
            S_SC_C:
            begin
                walk_next = walk_reg + CNT_W'(1);
                if (scat_last)
                begin
                    converted_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SC_A;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            num_columns_reg <= NCOL_MAX;
            entry_count_reg <= '0;
            converted_reg   <= 1'b0;
            walk_reg        <= '0;
            sum_reg         <= '0;
            wb_valid_reg    <= 1'b0;
            wb_idx_reg      <= '0;
            ld2_valid_reg   <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            p_valid_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            converted_reg   <= converted_next;
            walk_reg        <= walk_next;
            sum_reg         <= sum_next;
            wb_valid_reg    <= wb_valid_next;
            wb_idx_reg      <= wb_idx_next;
            ld2_valid_reg   <= load_ok;
            fwd_valid_reg   <= ld2_valid_reg;
            if (cfg_write_en)
            begin
                num_columns_reg <= cfg_write_data;
            end
            if (accept)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_adv)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_valid_reg && p_adv)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            ld2_addr_reg <= cnt_raddr;
        end
        fwd_addr_reg <= ld2_addr_reg;
        fwd_data_reg <= inc_count;
        if (accept)
        begin
            p_op_reg     <= in_op;
            p_status_reg <= in_status;
        end
        if (p_valid_reg && p_adv)
        begin
            status_reg    <= p_status_reg;
            col_start_reg <= ((p_op_reg == OP_READ_START) && (p_status_reg == ST_OK))
                             ? start_rdata : '0;
            out_row_reg   <= ((p_op_reg == OP_READ_ENTRY) && (p_status_reg == ST_OK))
                             ? sort_rdata[ROW_W-1:0] : '0;
            out_value_reg <= ((p_op_reg == OP_READ_ENTRY) && (p_status_reg == ST_OK))
                             ? sort_rdata[ROW_W +: VAL_W] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_value_reg, out_row_reg, col_start_reg});
    assign m_tuser  = status_reg;

    `CCSC_ASSERT_NOW(a_entry_bound, entry_count_reg <= ENTRY_MAX,
        "Entry count exceeds the tuple store depth.")
    `CCSC_ASSERT_NOW(a_scatter_slot, (state_reg != S_SC_C) || (ns_rdata < entry_count_reg),
        "Scatter slot lies beyond the stored entries.")
    `CCSC_ASSERT_NOW(a_count_port, !ld2_valid_reg || (state_reg == S_IDLE),
        "Count increment overlaps a walk of the count memory.")
    `CCSC_ASSERT_NEXT(a_convert_done, (state_reg == S_SC_C) && scat_last,
        converted_reg && (state_reg == S_IDLE),
        "Scatter of the last entry did not finish the conversion.")
    `CCSC_ASSERT_NEXT(a_result_hold, p_valid_reg && !p_adv,
        p_valid_reg && $stable(p_status_reg),
        "Pending result changed while the output was stalled.")

endmodule

[tb/sv/csc_result_checker.sv]
// Checker that predicts the converter's results from the observed transfers and compares them.
module csc_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [ccsc_pkg::NCOL_W-1:0]    cfg_write_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ccsc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ccsc_pkg::OP_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ccsc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [ccsc_pkg::ST_W-1:0]      m_tuser,
    output int                             results_owed,
    output int                             failures
);

    import ccsc_pkg::*;

    typedef struct packed {
        opcode_t           op;
        logic [CNT_W-1:0]  start;
        logic [ROW_W-1:0]  row;
        logic [VAL_W-1:0]  val;
        status_t           st;
    } csc_result_t;

    logic [CNT_W-1:0]  col_tally     [0:CTAB_DEPTH-1];
    logic [CNT_W-1:0]  free_slot     [0:CTAB_DEPTH-1];
    logic [ROW_W-1:0]  tuple_row_mem [0:MAX_ENTRIES-1];
    logic [COL_W-1:0]  tuple_col_mem [0:MAX_ENTRIES-1];
    logic [VAL_W-1:0]  tuple_val_mem [0:MAX_ENTRIES-1];
    logic [ROW_W-1:0]  csc_row_mem   [0:MAX_ENTRIES-1];
    logic [VAL_W-1:0]  csc_val_mem   [0:MAX_ENTRIES-1];
    logic [CNT_W-1:0]  tuple_total;
    logic              is_converted;
    logic [NCOL_W-1:0] ncol_reg;

    csc_result_t pending_csc_results[$];
    int          mismatch_total = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_total++;
    endtask

    function automatic csc_result_t apply_csc_op(input opcode_t op,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col,
                                                 input logic [VAL_W-1:0] val,
                                                 input logic [IDX_W-1:0] idx);
        csc_result_t        res;
        int unsigned        ncol;
        int                 i;
        int                 k;
        logic [CNT_W-1:0]   slot;
        logic [CADDR_W-1:0] cidx;
        logic [EADDR_W-1:0] eidx;
        res = '0;
        res.op = op;
        res.st = ST_OK;
        ncol = (ncol_reg > NCOL_MAX) ? MAX_COLUMNS : ncol_reg;
        case (op)
            OP_LOAD:
            begin
                // A new load after a conversion starts a new matrix, even if it fails.
                if (is_converted)
                begin
                    for (i = 0; i < CTAB_DEPTH; i++)
                    begin
                        col_tally[CADDR_W'(i)] = '0;
                    end
                    tuple_total = '0;
                    is_converted = 1'b0;
                end
                if (col >= ncol || row >= MAX_ROWS || tuple_total >= MAX_ENTRIES)
                begin
                    res.st = ST_BAD_LOAD;
                end
                else
                begin
                    eidx = tuple_total[EADDR_W-1:0];
                    tuple_row_mem[eidx] = row;
                    tuple_col_mem[eidx] = col;
                    tuple_val_mem[eidx] = val;
                    cidx = CADDR_W'(col) + CADDR_W'(1);
                    col_tally[cidx] = col_tally[cidx] + CNT_W'(1);
                    tuple_total = tuple_total + CNT_W'(1);
                end
            end
            OP_CONVERT:
            begin
                if (!is_converted)
                begin
                    for (i = 1; i <= MAX_COLUMNS; i++)
                    begin
                        col_tally[CADDR_W'(i)] = col_tally[CADDR_W'(i)]
                                                 + col_tally[CADDR_W'(i - 1)];
                    end
                    for (i = 0; i <= MAX_COLUMNS; i++)
                    begin
                        free_slot[CADDR_W'(i)] = col_tally[CADDR_W'(i)];
                    end
                    for (k = 0; k < int'(tuple_total); k++)
                    begin
                        eidx = EADDR_W'(k);
                        cidx = CADDR_W'(tuple_col_mem[eidx]);
                        slot = free_slot[cidx];
                        csc_row_mem[slot[EADDR_W-1:0]] = tuple_row_mem[eidx];
                        csc_val_mem[slot[EADDR_W-1:0]] = tuple_val_mem[eidx];
                        free_slot[cidx] = slot + CNT_W'(1);
                    end
                    is_converted = 1'b1;
                end
            end
            OP_READ_START:
            begin
                if (!is_converted)
                begin
                    res.st = ST_NOT_CONVERTED;
                end
                else if (idx > ncol)
                begin
                    res.st = ST_BAD_INDEX;
                end
                else
                begin
                    res.start = col_tally[idx[CADDR_W-1:0]];
                end
            end
            default:
            begin
                if (!is_converted)
                begin
                    res.st = ST_NOT_CONVERTED;
                end
                else if (idx >= tuple_total)
                begin
                    res.st = ST_BAD_INDEX;
                end
                else
                begin
                    res.row = csc_row_mem[idx[EADDR_W-1:0]];
                    res.val = csc_val_mem[idx[EADDR_W-1:0]];
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        csc_result_t want;
        csc_result_t got;
        int          c;
        if (!rst_n)
        begin
            ncol_reg = NCOL_MAX;
            tuple_total = '0;
            is_converted = 1'b0;
            for (c = 0; c < CTAB_DEPTH; c++)
            begin
                col_tally[CADDR_W'(c)] = '0;
            end
            pending_csc_results.delete();
        end
        else
        begin
            if (cfg_write_en)
            begin
                ncol_reg = cfg_write_data;
            end
            if (s_tvalid && s_tready)
            begin
                pending_csc_results.push_back(apply_csc_op(opcode_t'(s_tuser),
                    s_tdata[ROW_W-1:0],
                    s_tdata[ROW_W +: COL_W],
                    s_tdata[ROW_W+COL_W +: VAL_W],
                    s_tdata[ROW_W+COL_W+VAL_W +: IDX_W]));
            end
            if (m_tvalid && m_tready)
            begin
                got.start = m_tdata[CNT_W-1:0];
                got.row   = m_tdata[CNT_W +: ROW_W];
                got.val   = m_tdata[CNT_W+ROW_W +: VAL_W];
                got.st    = status_t'(m_tuser);
                if (pending_csc_results.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "result transfer with no operation awaiting it, status %0d",
                        m_tuser));
                end
                else
                begin
                    want = pending_csc_results.pop_front();
                    if (got.start !== want.start)
                    begin
                        report_mismatch($sformatf("%s col_start got %0d expected %0d",
                                                  want.op.name(), got.start, want.start));
                    end
                    if (got.row !== want.row)
                    begin
                        report_mismatch($sformatf("%s out_row got %0d expected %0d",
                                                  want.op.name(), got.row, want.row));
                    end
                    if (got.val !== want.val)
                    begin
                        report_mismatch($sformatf("%s out_value got %h expected %h",
                                                  want.op.name(), got.val, want.val));
                    end
                    if (m_tuser !== want.st)
                    begin
                        report_mismatch($sformatf("%s status got %0d expected %0d",
                                                  want.op.name(), m_tuser, want.st));
                    end
                end
            end
        end
        results_owed <= pending_csc_results.size();
        failures <= mismatch_total;
    end

endmodule

[tb/sv/tb_coo_to_csc_converter.sv]
// Testbench top for the sparse tuple to compressed sparse column converter.
module tb_coo_to_csc_converter;
    import ccsc_pkg::*;

    localparam int QUIET_LIMIT   = 60000;
    localparam int RANDOM_ITEMS  = 1370;
    localparam int SETTLE_CYCLES = 32;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [NCOL_W-1:0]    cfg_write_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;
    int                   results_owed;
    int                   failures;

    int          burst_left = 0;
    int          quiet_cycles = 0;
    int          ops_sent = 0;
    int unsigned ncol_now = MAX_COLUMNS;
    int unsigned loaded_now = 0;
    logic        converted_now = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    coo_to_csc_converter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

    csc_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .results_owed   (results_owed),
        .failures       (failures)
    );

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [NCOL_W-1:0] pick_columns();
        case ($urandom_range(0, 11))
            0: return NCOL_W'(1);
            1: return NCOL_MAX;
            2: return '1;
            3: return '0;
            4, 5, 6: return NCOL_W'($urandom_range(2, 16));
            default: return NCOL_W'($urandom_range(1, MAX_COLUMNS));
        endcase
    endfunction

    task automatic send_op(input opcode_t op, input int unsigned row,
                           input int unsigned col, input logic [VAL_W-1:0] val,
                           input int unsigned idx);
        int               gap;
        logic [COL_W-1:0] col_bits;
        col_bits = COL_W'(col);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({IDX_W'(idx), val, col_bits, ROW_W'(row)});
        do @(posedge clk); while (!s_tready);
        ops_sent++;
        if (op == OP_LOAD)
        begin
            if (converted_now)
            begin
                loaded_now = 0;
                converted_now = 1'b0;
            end
            if (col_bits < ncol_now && loaded_now < MAX_ENTRIES)
            begin
                loaded_now++;
            end
        end
        else if (op == OP_CONVERT)
        begin
            converted_now = 1'b1;
        end
    endtask

    task automatic set_columns(input logic [NCOL_W-1:0] cols);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0 || !s_tready) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cols;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        burst_left = 0;
        ncol_now = (cols > NCOL_MAX) ? MAX_COLUMNS : cols;
    endtask

    task automatic send_stray_read();
        send_op(opcode_t'($urandom_range(OP_READ_START, OP_READ_ENTRY)), $urandom, $urandom,
                rand_value(), $urandom_range(0, MAX_ENTRIES));
    endtask

    initial
    begin
        int start_ops;
        int n_loads;
        int n_reads;
        int j;
        int unsigned col;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= OP_LOAD;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_op(OP_READ_START, 0, 0, 0, 0);
        send_op(OP_READ_ENTRY, 0, 0, 0, 0);
        send_op(OP_CONVERT, 0, 0, 0, 0);
        send_op(OP_READ_START, 0, 0, 0, MAX_COLUMNS);
        send_op(OP_READ_START, 0, 0, 0, MAX_COLUMNS + 1);
        send_op(OP_READ_ENTRY, 0, 0, 0, 0);
        send_op(OP_LOAD, '1, '1, '1, MAX_ENTRIES);
        send_op(OP_LOAD, 0, 0, 0, 0);
        send_op(OP_LOAD, 512, '1, 64'h0123_4567_89ab_cdef, 0);
        send_op(OP_CONVERT, 0, 0, 0, 0);
        send_op(OP_CONVERT, '1, '1, '1, '1);
        send_op(OP_READ_START, 0, 0, 0, MAX_COLUMNS - 1);
        send_op(OP_READ_START, 0, 0, 0, MAX_COLUMNS);
        send_op(OP_READ_ENTRY, 0, 0, 0, 0);
        send_op(OP_READ_ENTRY, 0, 0, 0, 1);
        send_op(OP_READ_ENTRY, 0, 0, 0, 2);
        send_op(OP_READ_ENTRY, 0, 0, 0, 3);
        send_op(OP_READ_ENTRY, 0, 0, 0, MAX_ENTRIES);
        set_columns('0);
        send_op(OP_LOAD, 1, 0, rand_value(), 0);
        set_columns(NCOL_W'(3));
        send_op(OP_LOAD, 2, 3, rand_value(), 0);
        send_op(OP_LOAD, 7, 2, rand_value(), 0);
        // Shrinking the column count before the convert keeps the column 2 entry; it only narrows the start indices.
        set_columns(NCOL_W'(1));
        send_op(OP_CONVERT, 0, 0, 0, 0);
        send_op(OP_READ_START, 0, 0, 0, 1);
        send_op(OP_READ_START, 0, 0, 0, 2);
        send_op(OP_READ_ENTRY, 0, 0, 0, 0);
        set_columns('1);

        start_ops = ops_sent;
        while (ops_sent - start_ops < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                set_columns(pick_columns());
            end
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 40);
            for (j = 0; j < n_loads; j++)
            begin
                if (j == n_loads / 2 && $urandom_range(0, 7) == 0)
                begin
                    set_columns(pick_columns());
                end
                case ($urandom_range(0, 15))
                    0: col = $urandom_range(0, MAX_COLUMNS - 1);
                    1, 2, 3: col = (ncol_now < 4) ? 0 : $urandom_range(0, 3);
                    default: col = (ncol_now == 0) ? 0 : $urandom_range(0, ncol_now - 1);
                endcase
                send_op(OP_LOAD, $urandom_range(0, MAX_ROWS - 1), col, rand_value(),
                        $urandom_range(0, MAX_ENTRIES));
                if ($urandom_range(0, 19) == 0)
                begin
                    send_stray_read();
                end
            end
            send_op(OP_CONVERT, $urandom, $urandom, rand_value(), $urandom_range(0, MAX_ENTRIES));
            if ($urandom_range(0, 3) == 0)
            begin
                send_op(OP_CONVERT, $urandom, $urandom, rand_value(), $urandom);
            end
            n_reads = $urandom_range(3, 25);
            for (j = 0; j < n_reads; j++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_op(OP_READ_START, $urandom, $urandom, rand_value(),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_ENTRIES)
                                                        : $urandom_range(0, ncol_now));
                end
                else
                begin
                    send_op(OP_READ_ENTRY, $urandom, $urandom, rand_value(),
                            (loaded_now == 0 || $urandom_range(0, 7) == 0)
                                ? $urandom_range(0, MAX_ENTRIES)
                                : $urandom_range(0, loaded_now - 1));
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        int hold_left;
        int pattern_age;
        int taken;
        int next_hold_mark;
        logic [15:0] ready_pattern;
        hold_left = 0;
        pattern_age = 0;
        taken = 0;
        next_hold_mark = 150;
        ready_pattern = '1;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                taken++;
            end
            // Long hold-offs let the input side back up behind a stalled result.
            if (hold_left == 0 && taken == next_hold_mark)
            begin
                hold_left = 400;
                next_hold_mark = (next_hold_mark == 150) ? 700
                               : ((next_hold_mark == 700) ? 1200 : -1);
            end
            if (pattern_age == 0)
            begin
                pattern_age = 128;
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = $urandom;
                    2: ready_pattern = $urandom & $urandom;
                    default: ready_pattern = $urandom | $urandom;
                endcase
                if (ready_pattern == '0)
                begin
                    ready_pattern = 16'h0001;
                end
            end
            pattern_age--;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[coo_to_csc_converter.f]
+incdir+hdl
hdl/ccsc_pkg.sv
hdl/ccsc_ram.sv
hdl/coo_to_csc_converter.sv
tb/sv/csc_result_checker.sv
tb/sv/tb_coo_to_csc_converter.sv
